FILE: rtl/mes_pkg.sv
// Shared constants and control types for the midpoint ellipse stepper.
package mes_pkg;

    localparam int DEC_BITS    = 44;  // decision word, two's complement
    localparam int ACC_BITS    = 64;  // accumulator and product word
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;   // registers sit 4 bytes apart

    localparam logic REG_RADIUS_X = 1'b0;
    localparam logic REG_RADIUS_Y = 1'b1;

    // Accumulator command: acc = (clr ? 0 : acc) +/- (src << shift)
    typedef struct packed {
        logic       en;
        logic       clr;
        logic       sub;
        logic       use_ext;
        logic [1:0] shift;
    } t_acc_ctl;

    typedef struct packed {
        logic start;
        logic restart;
        logic out_free;
    } t_seq_cmd;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

endpackage

FILE: rtl/mes_mac.sv
// Shared multiplier with registered product and add/subtract accumulator.
module mes_mac #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                             i_clk,
    input  logic [2*RADIUS_BITS-1:0]         i_op_a,
    input  logic [2*RADIUS_BITS+1:0]         i_op_b,
    input  mes_pkg::t_acc_ctl                i_acc_ctl,
    input  logic [mes_pkg::ACC_BITS-1:0]     i_ext,
    output logic [mes_pkg::ACC_BITS-1:0]     o_prod,
    output logic [mes_pkg::ACC_BITS-1:0]     o_acc
);
    import mes_pkg::*;

    localparam int PROD_BITS = 4*RADIUS_BITS + 2;

    logic [PROD_BITS-1:0] w_prod_full;
    logic [ACC_BITS-1:0]  w_src;
    logic [ACC_BITS-1:0]  w_shifted;
    logic [ACC_BITS-1:0]  w_base;
    logic [ACC_BITS-1:0]  w_addend;
    logic [ACC_BITS-1:0]  n_acc;
    logic [ACC_BITS-1:0]  r_prod;
    logic [ACC_BITS-1:0]  r_acc;

    assign w_prod_full = i_op_a * i_op_b;

    always_comb begin
        w_src     = i_acc_ctl.use_ext ? i_ext : r_prod;
        w_shifted = w_src << i_acc_ctl.shift;
        w_base    = i_acc_ctl.clr ? '0 : r_acc;
        w_addend  = i_acc_ctl.sub ? ~w_shifted : w_shifted;
        // two's complement subtract: invert and carry in
        n_acc     = w_base + w_addend + ACC_BITS'(i_acc_ctl.sub);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ACC_BITS'(w_prod_full);
        if (i_acc_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

FILE: rtl/mes_seq.sv
// Step sequencer: ellipse state and micro-op schedule for the shared MAC.
module mes_seq #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mes_pkg::t_seq_cmd                i_cmd,
    output mes_pkg::t_seq_stat               o_stat,
    input  logic [RADIUS_BITS-1:0]           i_radius_x,
    input  logic [RADIUS_BITS-1:0]           i_radius_y,
    output logic [RADIUS_BITS-1:0]           o_point_x,
    output logic [RADIUS_BITS-1:0]           o_point_y,
    output logic [mes_pkg::DEC_BITS-1:0]     o_decision,
    output logic                             o_region,
    output logic                             o_last,
    output logic [2*RADIUS_BITS-1:0]         o_op_a,
    output logic [2*RADIUS_BITS+1:0]         o_op_b,
    output mes_pkg::t_acc_ctl                o_acc_ctl,
    output logic [mes_pkg::ACC_BITS-1:0]     o_ext,
    input  logic [mes_pkg::ACC_BITS-1:0]     i_prod,
    input  logic [mes_pkg::ACC_BITS-1:0]     i_acc
);
    import mes_pkg::*;

    localparam int RB      = RADIUS_BITS;
    localparam int MA      = 2*RB;
    localparam int MB      = 2*RB + 2;
    localparam int PA_BITS = 3*RB;
    localparam logic [ACC_BITS-1:0] QTR_ROUND = ACC_BITS'(3);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_Y, S_SQ_X, S_PREP, S_RS_SUB,
        S_R1_PA, S_R1_CMP, S_R1_ADD,
        S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6,
        S_R2N_A, S_R2N_B, S_R2N_C, S_R2P_A, S_R2P_B,
        S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic                r_restart, n_restart;
    logic [RB-1:0]       r_x, n_x;
    logic [RB-1:0]       r_y, n_y;
    logic [DEC_BITS-1:0] r_dec, n_dec;
    logic                r_region, n_region;
    logic                r_fin, n_fin;
    logic                r_sw, n_sw;
    logic [MA-1:0]       r_a, n_a;      // ry^2
    logic [MA-1:0]       r_b, n_b;      // rx^2
    logic [PA_BITS-1:0]  r_pa, n_pa;    // nx * ry^2

    logic                w_neg;
    logic [RB-1:0]       w_x_inc;
    logic [RB-1:0]       w_nx;
    logic [RB-1:0]       w_ny;
    logic                w_ny_zero;
    logic [RB:0]         w_t;
    logic [RB-1:0]       w_ym;
    logic [MA+1:0]       w_b3;
    logic                w_out_free;

    assign w_neg      = r_dec[DEC_BITS-1];
    assign w_out_free = i_cmd.out_free;

    // next point, from the stored point and the sign of the decision
    always_comb begin
        w_x_inc = r_x + 1'b1;
        if (!r_region) begin
            w_nx = w_x_inc;
            w_ny = w_neg ? r_y : r_y - 1'b1;
        end else begin
            w_nx = w_neg ? w_x_inc : r_x;
            w_ny = r_y - 1'b1;
        end
        w_ny_zero = (w_ny == '0);
        w_t       = {w_nx, 1'b1};
        w_ym      = w_ny - 1'b1;
        w_b3      = {1'b0, r_b, 1'b0} + (MA+2)'(r_b);
    end

    always_comb begin
        n_state   = r_state;
        n_restart = r_restart;
        n_x       = r_x;
        n_y       = r_y;
        n_dec     = r_dec;
        n_region  = r_region;
        n_fin     = r_fin;
        n_sw      = r_sw;
        n_a       = r_a;
        n_b       = r_b;
        n_pa      = r_pa;
        o_op_a    = '0;
        o_op_b    = '0;
        o_acc_ctl = '0;
        o_ext     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_restart = i_cmd.restart;
                    n_sw      = 1'b0;
                    n_state   = (i_cmd.restart || !r_fin) ? S_SQ_Y : S_FIN;
                end
            end
            S_SQ_Y: begin
                o_op_a  = MA'(i_radius_y);
                o_op_b  = MB'(i_radius_y);
                n_state = S_SQ_X;
            end
            S_SQ_X: begin
                o_op_a = MA'(i_radius_x);
                o_op_b = MB'(i_radius_x);
                n_a    = i_prod[MA-1:0];
                if (r_restart) begin
                    o_acc_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, use_ext: 1'b0, shift: 2'd0};
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                n_b = i_prod[MA-1:0];
                if (r_restart) begin
                    // acc = ry^2 + rx^2/4, then rx^2*ry comes off
                    o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b1, shift: 2'd0};
                    o_ext     = ACC_BITS'(i_prod[MA-1:2]);
                    o_op_a    = i_prod[MA-1:0];
                    o_op_b    = MB'(i_radius_y);
                    n_state   = S_RS_SUB;
                end else begin
                    o_acc_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, use_ext: 1'b1, shift: 2'd0};
                    o_ext     = ACC_BITS'(r_dec);
                    if (!r_region) begin
                        o_op_a  = r_a;
                        o_op_b  = MB'(w_nx);
                        n_state = S_R1_PA;
                    end else if (w_neg) begin
                        o_op_a  = r_a;
                        o_op_b  = MB'(w_nx);
                        n_state = S_R2N_A;
                    end else begin
                        o_op_a  = i_prod[MA-1:0];
                        o_op_b  = MB'(w_ny);
                        n_state = S_R2P_A;
                    end
                end
            end
            S_RS_SUB: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, use_ext: 1'b0, shift: 2'd0};
                n_state   = S_FIN;
            end
            S_R1_PA: begin
                n_pa      = i_prod[PA_BITS-1:0];
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b0, shift: 2'd1};
                o_op_a    = r_b;
                o_op_b    = MB'(w_ny);
                n_state   = S_R1_CMP;
            end
            S_R1_CMP: begin
                if (!w_neg) begin
                    o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, use_ext: 1'b0, shift: 2'd1};
                end
                // slope crosses one: restart the decision in region two
                if (!w_ny_zero && (ACC_BITS'(r_pa) > i_prod)) begin
                    n_sw    = 1'b1;
                    n_state = S_Q0;
                end else begin
                    n_state = S_R1_ADD;
                end
            end
            S_R1_ADD: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b1, shift: 2'd0};
                o_ext     = ACC_BITS'(r_a);
                n_state   = S_FIN;
            end
            // q = ry^2*(2x+1)^2 + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2
            S_Q0: begin
                o_op_a  = MA'(w_t);
                o_op_b  = MB'(w_t);
                n_state = S_Q1;
            end
            S_Q1: begin
                o_op_a  = r_a;
                o_op_b  = i_prod[MB-1:0];
                n_state = S_Q2;
            end
            S_Q2: begin
                o_op_a    = MA'(w_ym);
                o_op_b    = MB'(w_ym);
                o_acc_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, use_ext: 1'b0, shift: 2'd0};
                n_state   = S_Q3;
            end
            S_Q3: begin
                o_op_a  = r_b;
                o_op_b  = MB'(i_prod[MA-1:0]);
                n_state = S_Q4;
            end
            S_Q4: begin
                o_op_a    = r_b;
                o_op_b    = MB'(r_a);
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b0, shift: 2'd2};
                n_state   = S_Q5;
            end
            S_Q5: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, use_ext: 1'b0, shift: 2'd2};
                n_state   = S_Q6;
            end
            S_Q6: begin
                // bias negatives by 3 so the quarter shift truncates toward zero
                if (i_acc[ACC_BITS-1]) begin
                    o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b1, shift: 2'd0};
                    o_ext     = QTR_ROUND;
                end
                n_state = S_FIN;
            end
            S_R2N_A: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b0, shift: 2'd1};
                o_op_a    = r_b;
                o_op_b    = MB'(r_y);
                n_state   = S_R2N_B;
            end
            S_R2N_B: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, use_ext: 1'b0, shift: 2'd1};
                n_state   = S_R2N_C;
            end
            S_R2N_C: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b1, shift: 2'd0};
                o_ext     = ACC_BITS'(w_b3);
                n_state   = S_FIN;
            end
            S_R2P_A: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, use_ext: 1'b0, shift: 2'd1};
                n_state   = S_R2P_B;
            end
            S_R2P_B: begin
                o_acc_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, use_ext: 1'b1, shift: 2'd0};
                o_ext     = ACC_BITS'(r_b);
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    if (r_restart) begin
                        n_x      = '0;
                        n_y      = i_radius_y;
                        n_region = 1'b0;
                        if (i_radius_y == '0) begin
                            n_dec = '0;
                            n_fin = 1'b1;
                        end else begin
                            n_dec = i_acc[DEC_BITS-1:0];
                            n_fin = 1'b0;
                        end
                    end else if (!r_fin) begin
                        n_x   = w_nx;
                        n_y   = w_ny;
                        n_dec = i_acc[DEC_BITS-1:0];
                        if (r_sw) begin
                            n_region = 1'b1;
                            n_dec    = i_acc[DEC_BITS+1:2];
                        end
                        if (w_ny_zero) begin
                            if (!r_region) begin
                                n_region = (r_pa != '0);
                            end
                            n_dec = '0;
                            n_fin = 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_region <= 1'b0;
            r_fin    <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_region <= n_region;
            r_fin    <= n_fin;
        end
        r_restart <= n_restart;
        r_sw      <= n_sw;
        r_a       <= n_a;
        r_b       <= n_b;
        r_pa      <= n_pa;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_FIN) && w_out_free;
    assign o_point_x   = r_x;
    assign o_point_y   = r_y;
    assign o_decision  = r_dec;
    assign o_region    = r_region;
    assign o_last      = r_fin;

    // a finished quadrant always rests on the x axis with a cleared decision
    a_fin_on_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_y == '0 && r_dec == '0))
        else $error("finished point off the x axis or decision not cleared");

    // the point only moves when a result is committed
    a_point_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_FIN && w_out_free) |=> ($stable(r_x) && $stable(r_y) && $stable(r_dec)))
        else $error("point changed outside commit");

    // an advance moves y down by at most one
    a_y_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free && !r_restart && !r_fin)
        |=> (r_y == $past(r_y) || r_y == $past(r_y) - 1'b1))
        else $error("y stepped by more than one");

endmodule

FILE: rtl/midpoint_ellipse_stepper.sv
// Top level of the midpoint ellipse stepper: APB registers, stream ports, sequencer and MAC.
//
//  channel   dir   handshake                   payload
//  --------  ----  --------------------------  ----------------------------------------
//  s_axis    in    s_axis_tvalid/tready        tdata[0] restart
//  m_axis    out   m_axis_tvalid/tready        tdata point_x, point_y, decision; tuser
//                                              region; tlast last
//  apb       in    psel & penable & pwrite     radius_x at 0x0, radius_y at 0x4
//
//  Items are scheduled one after another on the one shared multiplier (one
//  product per cycle, registered before accumulation); each kind of item has
//  its own schedule: restart, region-one step, region-two step, the step that
//  enters region two, and an advance after the last point.
//  Reset clears the point to (0, 0) with last set and the radii to zero; no
//  clearing pass. s_axis_tready is high only while the sequencer is idle; an
//  item finished while m_axis is stalled waits in its commit cycle, and the
//  held result keeps m_axis valid until it is taken.
module midpoint_ellipse_stepper #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // APB configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mes_pkg::APB_AW-1:0]             paddr,
    input  logic [mes_pkg::APB_DW-1:0]             pwdata,
    output logic [mes_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,  // [0] restart
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // point_x, point_y, decision from bit 0 up, zero padded to bytes
    output logic [((2*RADIUS_BITS+mes_pkg::DEC_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                                   m_axis_tuser,  // region
    output logic                                   m_axis_tlast   // last
);
    import mes_pkg::*;

    localparam int RB            = RADIUS_BITS;
    localparam int OUT_DATA_BITS = ((2*RB + DEC_BITS + 7)/8)*8;

    logic [RB-1:0]       r_radius_x;
    logic [RB-1:0]       r_radius_y;
    logic                r_out_valid;

    logic                w_cfg_wr;
    t_seq_cmd            w_cmd;
    t_seq_stat           w_stat;
    logic [RB-1:0]       w_point_x;
    logic [RB-1:0]       w_point_y;
    logic [DEC_BITS-1:0] w_decision;
    logic                w_region;
    logic                w_last;
    logic [2*RB-1:0]     w_op_a;
    logic [2*RB+1:0]     w_op_b;
    t_acc_ctl            w_acc_ctl;
    logic [ACC_BITS-1:0] w_ext;
    logic [ACC_BITS-1:0] w_prod;
    logic [ACC_BITS-1:0] w_acc;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_x <= '0;
            r_radius_y <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[REG_SEL_BIT])
                REG_RADIUS_X: r_radius_x <= pwdata[RB-1:0];
                REG_RADIUS_Y: r_radius_y <= pwdata[RB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_SEL_BIT])
            REG_RADIUS_X: prdata = APB_DW'(r_radius_x);
            REG_RADIUS_Y: prdata = APB_DW'(r_radius_y);
            default:      prdata = '0;
        endcase
    end

    // input side: one item in flight
    assign s_axis_tready  = w_stat.idle;
    assign w_cmd.start    = s_axis_tvalid && s_axis_tready;
    assign w_cmd.restart  = s_axis_tdata[0];
    // the commit may proceed when the held result is gone or leaves this cycle
    assign w_cmd.out_free = !r_out_valid || m_axis_tready;

    // output valid; the point registers in the sequencer hold the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_BITS'({w_decision, w_point_y, w_point_x});
    assign m_axis_tuser  = w_region;
    assign m_axis_tlast  = w_last;

    mes_seq #(
        .RADIUS_BITS(RADIUS_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_radius_x (r_radius_x),
        .i_radius_y (r_radius_y),
        .o_point_x  (w_point_x),
        .o_point_y  (w_point_y),
        .o_decision (w_decision),
        .o_region   (w_region),
        .o_last     (w_last),
        .o_op_a     (w_op_a),
        .o_op_b     (w_op_b),
        .o_acc_ctl  (w_acc_ctl),
        .o_ext      (w_ext),
        .i_prod     (w_prod),
        .i_acc      (w_acc)
    );

    mes_mac #(
        .RADIUS_BITS(RADIUS_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_op_a    (w_op_a),
        .i_op_b    (w_op_b),
        .i_acc_ctl (w_acc_ctl),
        .i_ext     (w_ext),
        .o_prod    (w_prod),
        .o_acc     (w_acc)
    );

endmodule
